/* hw/rtl/qssd_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// qssd_pkg
// Shared types, character constants and hex helpers for the query string
// splitter and percent decoder.
// ============================================================================
package qssd_pkg;

    localparam int MaxResults = 4;
    localparam int CountW     = $clog2(MaxResults + 1);
    localparam int IdxW       = $clog2(MaxResults);

    localparam logic [7:0] CharPercent = 8'h25;
    localparam logic [7:0] CharPlus    = 8'h2B;
    localparam logic [7:0] CharAmp     = 8'h26;
    localparam logic [7:0] CharEq      = 8'h3D;
    localparam logic [7:0] CharSpace   = 8'h20;
    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharNine    = 8'h39;
    localparam logic [7:0] CharLowA    = 8'h61;
    localparam logic [7:0] CharLowF    = 8'h66;
    localparam logic [7:0] CharUpA     = 8'h41;
    localparam logic [7:0] CharUpF     = 8'h46;
    localparam logic [3:0] HexAlphaBase = 4'd10;

    // One result transaction without its last flag.
    typedef struct packed {
        logic [7:0] char_out;
        logic       in_value;
        logic       field_end;
    } result_t;

    // All results that one input item causes.
    typedef struct packed {
        result_t [MaxResults-1:0] ents;
        logic [CountW-1:0]        count;
    } batch_t;

    // Parser state carried from item to item.
    typedef struct packed {
        logic       value_phase;
        logic [1:0] escape_phase;
        logic [7:0] held_digit;
        logic       segment_open;
    } parse_state_t;

    function automatic logic hex_ok(input logic [7:0] c);
        hex_ok = ((c >= CharZero) && (c <= CharNine)) ||
                 ((c >= CharLowA) && (c <= CharLowF)) ||
                 ((c >= CharUpA)  && (c <= CharUpF));
    endfunction

    // Letters in either case carry their value minus nine in the low nibble.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if ((c >= CharZero) && (c <= CharNine)) begin
            hex_nibble = c[3:0];
        end
        else begin
            hex_nibble = c[3:0] + (HexAlphaBase - 4'd1);
        end
    endfunction

endpackage

/* hw/rtl/query_string_splitter_decoder.sv */
`timescale 1ns / 1ps
// ============================================================================
// query_string_splitter_decoder
// Splits a query string into key and value fields on '&' and '=', and
// percent-decodes the bytes of each field.
// ============================================================================
//
//   Channel | Handshake           | Payload
//   --------+---------------------+-----------------------------------------
//   input   | in_valid / in_stall | char_in, end_of_string
//   output  | out_valid/out_stall | char_out, in_value, field_end, last
//
// An accepted transaction lands in an input register. Once the output buffer
// can take its batch, the decoder turns it into a batch of zero to four
// results in one pass and the batch is loaded into the output buffer, which
// presents one result per cycle while out_stall is low. The output buffer's
// single result port paces the stream, so unstalled plain bytes flow at one per cycle.
// Reset (rst_n, asynchronous, active low) empties both stages and returns the
// parser to the start of a key with no escape pending.
// in_stall rises only while the input register holds an item and the output
// buffer cannot take its batch in this cycle.
// ============================================================================
module query_string_splitter_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] char_out,
    output logic       in_value,
    output logic       field_end,
    output logic       last
);
    import qssd_pkg::*;

    logic       item_valid_reg;
    logic       item_valid_next;
    logic [7:0] item_char_reg;
    logic       item_eos_reg;
    logic       buf_free;
    logic       take;
    logic       accept;
    batch_t     batch;

    // The held item moves on as soon as the output buffer has room for its
    // whole batch, which frees the input register for the next transaction
    // in the same cycle.
    assign take     = item_valid_reg && buf_free;
    assign in_stall = item_valid_reg && !buf_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (take)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // The payload needs no reset; the valid flag guards it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_char_reg <= char_in;
            item_eos_reg  <= end_of_string;
        end
    end

    qssd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item_char (item_char_reg),
        .item_eos  (item_eos_reg),
        .batch     (batch)
    );

    qssd_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .batch     (batch),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .in_value  (in_value),
        .field_end (field_end),
        .last      (last)
    );

`ifndef SYNTH
    // A held item that cannot move on is still held in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !buf_free |=> item_valid_reg)
        else $error("held input transaction dropped");

    // A result that is stalled at the output stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result withdrawn");

    // A batch is loaded only into an empty or draining output buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!out_valid || (!out_stall && last)))
        else $error("batch loaded over pending results");
`endif

endmodule

/* hw/rtl/qssd_decode.sv */
`timescale 1ns / 1ps
// ============================================================================
// qssd_decode
// Parser state and the combinational decode of one raw byte or end item into
// its batch of up to four results.
// ============================================================================
module qssd_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      item_char,
    input  logic            item_eos,
    output qssd_pkg::batch_t batch
);
    import qssd_pkg::*;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    parse_state_t st_reg;
    parse_state_t st_next;

    function automatic result_t mk(input logic [7:0] ch, input logic iv, input logic fe);
        result_t r;
        r.char_out  = ch;
        r.in_value  = iv;
        r.field_end = fe;
        mk = r;
    endfunction

    always_comb
    begin
        logic [CountW-1:0] n;
        logic              do_plain;
        logic [7:0]        c;
        n        = '0;
        do_plain = 1'b0;
        c        = item_char;
        st_next  = st_reg;
        batch    = '0;

        // A pending escape that breaks, or meets the end, goes out literally.
        if (item_eos || (st_reg.escape_phase == ESC_PCT && !hex_ok(c)) ||
            (st_reg.escape_phase == ESC_DIGIT && !hex_ok(c)))
        begin
            if (st_reg.escape_phase == ESC_PCT || st_reg.escape_phase == ESC_DIGIT)
            begin
                batch.ents[n[IdxW-1:0]] = mk(CharPercent, st_reg.value_phase, 1'b0);
                n = n + 1'b1;
            end
            if (st_reg.escape_phase == ESC_DIGIT)
            begin
                batch.ents[n[IdxW-1:0]] = mk(st_reg.held_digit, st_reg.value_phase, 1'b0);
                n = n + 1'b1;
            end
            st_next.escape_phase = ESC_NONE;
            st_next.held_digit   = '0;
        end

        if (item_eos)
        begin
            if (st_reg.segment_open)
            begin
                if (!st_reg.value_phase)
                begin
                    batch.ents[n[IdxW-1:0]] = mk(8'h00, 1'b0, 1'b1);
                    n = n + 1'b1;
                end
                batch.ents[n[IdxW-1:0]] = mk(8'h00, 1'b1, 1'b1);
                n = n + 1'b1;
            end
            st_next = '0;
        end
        else
        begin
            case (st_reg.escape_phase)
                ESC_PCT:
                begin
                    if (hex_ok(c))
                    begin
                        st_next.held_digit   = c;
                        st_next.escape_phase = ESC_DIGIT;
                    end
                    else
                    begin
                        do_plain = 1'b1;
                    end
                end
                ESC_DIGIT:
                begin
                    if (hex_ok(c))
                    begin
                        batch.ents[n[IdxW-1:0]] = mk({hex_nibble(st_reg.held_digit),
                                                      hex_nibble(c)},
                                                     st_reg.value_phase, 1'b0);
                        n = n + 1'b1;
                        st_next.escape_phase = ESC_NONE;
                        st_next.held_digit   = '0;
                    end
                    else
                    begin
                        do_plain = 1'b1;
                    end
                end
                default:
                begin
                    st_next.escape_phase = ESC_NONE;
                    do_plain = 1'b1;
                end
            endcase
        end

        if (do_plain)
        begin
            if (c == CharAmp)
            begin
                if (st_reg.segment_open)
                begin
                    if (!st_reg.value_phase)
                    begin
                        batch.ents[n[IdxW-1:0]] = mk(8'h00, 1'b0, 1'b1);
                        n = n + 1'b1;
                    end
                    batch.ents[n[IdxW-1:0]] = mk(8'h00, 1'b1, 1'b1);
                    n = n + 1'b1;
                end
                st_next.value_phase  = 1'b0;
                st_next.segment_open = 1'b0;
            end
            else
            begin
                st_next.segment_open = 1'b1;
                if (c == CharEq)
                begin
                    if (!st_reg.value_phase)
                    begin
                        batch.ents[n[IdxW-1:0]] = mk(8'h00, 1'b0, 1'b1);
                        st_next.value_phase = 1'b1;
                    end
                    else
                    begin
                        batch.ents[n[IdxW-1:0]] = mk(CharEq, 1'b1, 1'b0);
                    end
                    n = n + 1'b1;
                end
                else if (c == CharPercent)
                begin
                    st_next.escape_phase = ESC_PCT;
                end
                else
                begin
                    batch.ents[n[IdxW-1:0]] = mk((c == CharPlus) ? CharSpace : c,
                                                 st_reg.value_phase, 1'b0);
                    n = n + 1'b1;
                end
            end
        end

        batch.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (take)
        begin
            st_reg <= st_next;
        end
    end

`ifndef SYNTH
    // An end item leaves the parser exactly in its reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && item_eos |=> st_reg == '0)
        else $error("parser state not cleared after end of string");
`endif

endmodule

/* hw/rtl/qssd_serializer.sv */
`timescale 1ns / 1ps
// ============================================================================
// qssd_serializer
// Holds the batch of one item and hands its results out one per cycle while
// out_stall is low, marking the final one.
// ============================================================================
module qssd_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  qssd_pkg::batch_t batch,
    output logic             free,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       char_out,
    output logic             in_value,
    output logic             field_end,
    output logic             last
);
    import qssd_pkg::*;

    logic [CountW-1:0]        cnt_reg;
    logic [CountW-1:0]        cnt_next;
    logic [IdxW-1:0]          idx_reg;
    logic [IdxW-1:0]          idx_next;
    result_t [MaxResults-1:0] ent_reg;
    result_t                  cur;
    logic                     pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign last      = out_valid && ((CountW'(idx_reg) + 1'b1) == cnt_reg);
    assign free      = !out_valid || (pop && last);
    assign cur       = ent_reg[idx_reg];
    assign char_out  = cur.char_out;
    assign in_value  = cur.in_value;
    assign field_end = cur.field_end;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (pop)
        begin
            if (last)
            begin
                cnt_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (load)
        begin
            cnt_next = batch.count;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= batch.ents;
        end
    end

`ifndef SYNTH
    // The pending count never exceeds the largest batch.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CountW'(MaxResults))
        else $error("result count out of range");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the query string splitter and percent decoder. A
// behavioral decoder predicts every result transaction from the accepted
// input bytes, and a checker compares each accepted result, field by field,
// against the oldest prediction. Both channels idle and stall at random.
// ============================================================================
module testbench;

    import qssd_pkg::*;

    // Escape tracking of the behavioral decoder.
    localparam logic [1:0] EscNone    = 2'd0;
    localparam logic [1:0] EscPercent = 2'd1;
    localparam logic [1:0] EscDigit   = 2'd2;

    // Cycles that an item with no results may still spend inside the block
    // (input register plus output buffer), with some margin.
    localparam int DrainCycles    = 8;
    // The longest legal quiet spell is a long sender gap or a long receiver stall;
    // the limit is set well above both.
    localparam int WatchdogLimit  = 2000;
    localparam int RandomItems    = 460;

    // One predicted result transaction.
    typedef struct {
        logic [7:0] ch;
        logic       inval;
        logic       fend;
        logic       lst;
    } decoded_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [7:0] char_in       = 8'h00;
    logic       end_of_string = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [7:0] char_out;
    logic       in_value;
    logic       field_end;
    logic       last;

    // Results still owed by the block, oldest first.
    decoded_t   decoded_q[$];
    // Results of the item currently being predicted.
    decoded_t   batch_q[$];
    decoded_t   want;

    // State of the behavioral decoder.
    logic       dec_in_value;
    logic [1:0] dec_escape;
    logic [7:0] dec_held;
    logic       dec_seg_open;

    int         errors      = 0;
    int         items_sent  = 0;
    int         idle_cycles = 0;
    int         stall_left  = 0;
    int         stall_roll;
    // When set, the matching side runs with no idle cycles at all.
    bit         calm_in     = 1'b0;
    bit         calm_out    = 1'b0;

    query_string_splitter_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_in       (char_in),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .char_out      (char_out),
        .in_value      (in_value),
        .field_end     (field_end),
        .last          (last)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Behavioral decoder
    // ------------------------------------------------------------------------

    function automatic bit is_hex_char(input logic [7:0] c);
        return ((c >= CharZero) && (c <= CharNine)) ||
               ((c >= CharLowA) && (c <= CharLowF)) ||
               ((c >= CharUpA)  && (c <= CharUpF));
    endfunction

    function automatic logic [3:0] hex_of(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= CharZero) && (c <= CharNine)) begin
            v = c - CharZero;
        end
        else if ((c >= CharLowA) && (c <= CharLowF)) begin
            v = c - CharLowA + 8'd10;
        end
        else begin
            v = c - CharUpA + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic void emit_result(input logic [7:0] ch, input logic inval,
                                        input logic fend);
        decoded_t r;
        r.ch    = ch;
        r.inval = inval;
        r.fend  = fend;
        r.lst   = 1'b0;
        batch_q.push_back(r);
    endfunction

    // A pending escape that cannot complete comes out literally.
    function automatic void flush_escape_literal();
        if (dec_escape == EscPercent) begin
            emit_result(CharPercent, dec_in_value, 1'b0);
        end
        else if (dec_escape == EscDigit) begin
            emit_result(CharPercent, dec_in_value, 1'b0);
            emit_result(dec_held, dec_in_value, 1'b0);
        end
        dec_escape = EscNone;
        dec_held   = 8'h00;
    endfunction

    // A segment that saw any byte closes its key (if still open) and value.
    function automatic void close_pair();
        if (dec_seg_open) begin
            if (!dec_in_value) begin
                emit_result(8'h00, 1'b0, 1'b1);
            end
            emit_result(8'h00, 1'b1, 1'b1);
        end
        dec_in_value = 1'b0;
        dec_seg_open = 1'b0;
    endfunction

    function automatic void take_plain(input logic [7:0] c);
        if (c == CharAmp) begin
            close_pair();
        end
        else begin
            dec_seg_open = 1'b1;
            if (c == CharEq) begin
                if (!dec_in_value) begin
                    emit_result(8'h00, 1'b0, 1'b1);
                    dec_in_value = 1'b1;
                end
                else begin
                    emit_result(CharEq, dec_in_value, 1'b0);
                end
            end
            else if (c == CharPercent) begin
                dec_escape = EscPercent;
            end
            else if (c == CharPlus) begin
                emit_result(CharSpace, dec_in_value, 1'b0);
            end
            else begin
                emit_result(c, dec_in_value, 1'b0);
            end
        end
    endfunction

    function automatic void reset_decoder();
        dec_in_value = 1'b0;
        dec_escape   = EscNone;
        dec_held     = 8'h00;
        dec_seg_open = 1'b0;
    endfunction

    // Works out the results of one accepted input transaction and queues them.
    function automatic void decode_item(input logic [7:0] c, input logic eos);
        batch_q.delete();
        if (eos) begin
            flush_escape_literal();
            close_pair();
            reset_decoder();
        end
        else if (dec_escape == EscPercent) begin
            if (is_hex_char(c)) begin
                dec_held   = c;
                dec_escape = EscDigit;
            end
            else begin
                flush_escape_literal();
                take_plain(c);
            end
        end
        else if (dec_escape == EscDigit) begin
            if (is_hex_char(c)) begin
                emit_result({hex_of(dec_held), hex_of(c)}, dec_in_value, 1'b0);
                dec_escape = EscNone;
                dec_held   = 8'h00;
            end
            else begin
                flush_escape_literal();
                take_plain(c);
            end
        end
        else begin
            take_plain(c);
        end
        if (batch_q.size() > 0) begin
            batch_q[batch_q.size() - 1].lst = 1'b1;
        end
        foreach (batch_q[i]) begin
            decoded_q.push_back(batch_q[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h",
                     $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Outputs and stall only move at rising edges, so sampling at the falling
    // edge sees exactly what the next rising edge will accept.
    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, char_out %02h in_value %0b field_end %0b last %0b",
                         $time, char_out, in_value, field_end, last);
                errors++;
            end
            else begin
                want = decoded_q.pop_front();
                check_field("char_out", want.ch, char_out);
                check_field("in_value", {7'd0, want.inval}, {7'd0, in_value});
                check_field("field_end", {7'd0, want.fend}, {7'd0, field_end});
                check_field("last", {7'd0, want.lst}, {7'd0, last});
            end
        end
    end

    // Counts cycles in which neither channel moves a transaction.
    always @(negedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end
            else begin
                idle_cycles++;
            end
            if (idle_cycles >= WatchdogLimit) begin
                $display("%0t: watchdog, no transaction for %0d cycles, %0d results pending",
                         $time, idle_cycles, decoded_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver back-pressure: mostly free, short stalls, now and then a long one.
    always @(posedge clk) begin
        if (!rst_n || calm_out) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70) begin
                out_stall <= 1'b0;
            end
            else if (stall_roll < 96) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Sends one input transaction, after a random gap unless the input side is
    // calm. Called and returning in a rising-edge time step; valid is left high
    // so that back-to-back transactions need no idle cycle.
    task automatic send_item(input logic [7:0] c, input logic eos);
        int roll;
        int gap;
        gap = 0;
        if (!calm_in) begin
            roll = $urandom_range(0, 99);
            if (roll >= 92) begin
                gap = $urandom_range(8, 30);
            end
            else if (roll >= 65) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        char_in       <= c;
        end_of_string <= eos;
        forever begin
            @(negedge clk);
            if (!in_stall) begin
                break;
            end
        end
        decode_item(c, eos);
        items_sent++;
        @(posedge clk);
    endtask

    // Stops sending, waits for every owed result, then lets the block settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] pick_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return CharZero + 8'(v);
        end
        return ($urandom_range(0, 1) ? CharLowA : CharUpA) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] pick_alnum();
        int v;
        v = $urandom_range(0, 61);
        if (v < 10) begin
            return CharZero + 8'(v);
        end
        else if (v < 36) begin
            return CharLowA + 8'(v - 10);
        end
        return CharUpA + 8'(v - 36);
    endfunction

    // A byte that breaks an escape; separators and a fresh '%' are favored.
    function automatic logic [7:0] pick_non_hex();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: return CharAmp;
            1: return CharPercent;
            2: return CharEq;
            default: begin
                do begin
                    b = 8'($urandom_range(0, 255));
                end while (is_hex_char(b));
                return b;
            end
        endcase
    endfunction

    // One piece of key or value content, one to three input transactions.
    task automatic send_field_piece();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            send_item(pick_alnum(), 1'b0);
        end
        else if (roll < 55) begin
            send_item(CharPlus, 1'b0);
        end
        else if (roll < 70) begin
            send_item(CharPercent, 1'b0);
            send_item(pick_hex(), 1'b0);
            send_item(pick_hex(), 1'b0);
        end
        else if (roll < 78) begin
            send_item(CharPercent, 1'b0);
            if ($urandom_range(0, 1)) begin
                send_item(pick_hex(), 1'b0);
            end
            send_item(pick_non_hex(), 1'b0);
        end
        else if (roll < 90) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        else begin
            send_item(CharEq, 1'b0);
        end
    endtask

    // A well-formed query string with random content, ended by an end item
    // whose ignored byte is random.
    task automatic send_query_string();
        int segs;
        int key_len;
        int val_len;
        segs = $urandom_range(0, 4);
        for (int s = 0; s < segs; s++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(CharAmp, 1'b0);
            end
            key_len = $urandom_range(0, 5);
            for (int k = 0; k < key_len; k++) begin
                send_field_piece();
            end
            if ($urandom_range(0, 4) != 0) begin
                send_item(CharEq, 1'b0);
                val_len = $urandom_range(0, 5);
                for (int v = 0; v < val_len; v++) begin
                    send_field_piece();
                end
            end
            if ((s < segs - 1) || ($urandom_range(0, 5) == 0)) begin
                send_item(CharAmp, 1'b0);
            end
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Raw bytes of any value, then an end item.
    task automatic send_noise_string();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Splitting: an end item with nothing open, empty segments at the start,
    // in the middle and at the end, a segment of only '=', and a second '='
    // that belongs to the value.
    task automatic test_segments();
        send_item(8'h00, 1'b1);
        send_text("&&=&a=b=&");
        send_item(8'hFF, 1'b1);
        wait_drained();
    endtask

    // Decoding: escapes in lower and upper case, '+' as a space, and an
    // escape cut short by the end item with one hex digit held.
    task automatic test_escapes();
        send_text("%4a%fF+%0");
        send_item(8'h00, 1'b1);
        wait_drained();
    endtask

    // Broken escapes: '%' before a non-hex byte, '%' before another '%', a
    // held digit broken by a separator; then zero and all-ones raw bytes.
    task automatic test_broken_escapes();
        send_text("%g%%1&");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        wait_drained();
    endtask

    // Random strings, mostly well-formed, with one full pause in the middle
    // and stretches where one or both sides never idle.
    task automatic test_random_strings();
        int start_count;
        bit paused;
        start_count = items_sent;
        paused      = 1'b0;
        while (items_sent - start_count < RandomItems) begin
            calm_in  = ($urandom_range(0, 7) == 0);
            calm_out = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0) begin
                send_noise_string();
            end
            else begin
                send_query_string();
            end
            if (!paused && (items_sent - start_count >= RandomItems / 2)) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        calm_in  = 1'b0;
        calm_out = 1'b0;
        wait_drained();
    endtask

    initial begin
        reset_decoder();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_segments();
        test_escapes();
        test_broken_escapes();
        test_random_strings();

        if (errors == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
